@@ hw/rtl/lwma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lwma_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;

  // weights run from the window length down to one
  localparam int WEIGHT_W = CFG_W;
  // weighted sum: 16-bit sample times weight, summed over up to 31 taps
  localparam int ACC_W    = 26;
  localparam int MAG_W    = ACC_W - 1;
  // sum of weights, at most 31 * 32 / 2 = 496
  localparam int WSUM_W   = 9;
  localparam int DIV_CNT_W = $clog2(MAG_W);

  // shortest window that is averaged
  localparam logic [CFG_W-1:0] MIN_WINDOW = CFG_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [CFG_W-1:0]    window_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic        [WSUM_W-1:0]   wsum_t;

  // sequencer to history store
  typedef struct packed {
    logic wr_en;    // store a new sample, aim read pointer at it
    logic rd_step;  // move read pointer one sample older
  } hist_ctl_t;

  // history store to sequencer
  typedef struct packed {
    logic win_ok;   // window is averaged once the pending sample is stored
  } hist_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/lwma_hist.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lwma_hist #(
  parameter int DEPTH = 20
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lwma_pkg::hist_ctl_t ctl,
  input  lwma_pkg::sample_t   wr_data,
  input  lwma_pkg::window_t   window,
  output lwma_pkg::hist_stat_t stat,
  output lwma_pkg::sample_t   rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > lwma_pkg::CFG_W) ? CNT_W : lwma_pkg::CFG_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  lwma_pkg::sample_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_after;

  // fill count as it stands once the pending sample is stored
  assign fill_after = (fill_r == FULL_CNT) ? fill_r : fill_r + 1'b1;

  assign stat.win_ok = (window >= lwma_pkg::MIN_WINDOW) &&
                       (CMP_W'(fill_after) >= CMP_W'(window));

  assign rd_data = mem_r[rd_ptr_r];

  // sample storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (ctl.wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
        rd_ptr_r <= wr_ptr_r;
        fill_r   <= fill_after;
      end else if (ctl.rd_step) begin
        rd_ptr_r <= (rd_ptr_r == '0) ? LAST_SLOT : rd_ptr_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lwma_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lwma_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  lwma_pkg::acc_t    dividend,
  input  lwma_pkg::wsum_t   divisor,
  output logic              done,
  output lwma_pkg::sample_t quotient
);

  localparam int MAG_W  = lwma_pkg::MAG_W;
  localparam int WSUM_W = lwma_pkg::WSUM_W;
  localparam int CNT_W  = lwma_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MAG_W-1:0]    q_r;
  logic [WSUM_W-1:0]   rem_r;
  logic [WSUM_W-1:0]   dvs_r;
  lwma_pkg::sample_t   quot_r;

  lwma_pkg::acc_t      abs_val;
  logic [WSUM_W:0]     rem_sh;
  logic                q_bit;
  logic [WSUM_W:0]     rem_sub;
  logic [MAG_W-1:0]    q_nxt;
  logic [MAG_W-1:0]    q_fin;

  assign abs_val = dividend[lwma_pkg::ACC_W-1] ? -dividend : dividend;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, q_r[MAG_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_sub = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    q_nxt   = {q_r[MAG_W-2:0], q_bit};
    q_fin   = neg_r ? (~q_nxt + 1'b1) : q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST_STEP)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[lwma_pkg::ACC_W-1];
      q_r   <= abs_val[MAG_W-1:0];
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_sub[WSUM_W-1:0];
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        quot_r <= q_fin[lwma_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

@@ hw/rtl/linear_weighted_moving_average.sv @@
// sequence: a bypassed request (window not averaged) goes straight to the output state;
//   averaging a window of N samples takes N multiply-accumulate steps, 25 divider steps
// requests: one at a time; the next is taken once the result is registered, and the
//   output state holds while out_valid is high and out_ready is low (back-pressure)
// reset: rst_n synchronous active low clears pointers, fill count, window length
//   and output valid; stored samples are not cleared
`timescale 1ns / 1ps
`default_nettype none

module linear_weighted_moving_average #(
  parameter int HISTORY_DEPTH = 20
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [15:0]              in_sample,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [15:0]             out_filtered,
  input  wire                            cfg_wr_en,
  input  wire [lwma_pkg::CFG_W-1:0]      cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DIV,
    S_OUT
  } state_t;

  state_t                state_r;
  lwma_pkg::window_t     window_r;
  logic [lwma_pkg::WEIGHT_W-1:0] weight_r;
  lwma_pkg::acc_t        acc_r;
  lwma_pkg::wsum_t       wsum_r;
  lwma_pkg::sample_t     res_r;
  logic                  div_start_r;
  logic                  out_valid_r;
  lwma_pkg::sample_t     out_filtered_r;

  lwma_pkg::hist_ctl_t   hist_ctl;
  lwma_pkg::hist_stat_t  hist_stat;
  lwma_pkg::sample_t     rd_data;
  logic                  in_fire;
  logic signed [lwma_pkg::SAMPLE_W+lwma_pkg::WEIGHT_W:0] prod;
  logic                  div_done;
  lwma_pkg::sample_t     div_quot;

  assign in_ready     = (state_r == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  assign hist_ctl = '{wr_en: in_fire, rd_step: (state_r == S_MAC)};

  lwma_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (hist_ctl),
    .wr_data (in_sample),
    .window  (window_r),
    .stat    (hist_stat),
    .rd_data (rd_data)
  );

  lwma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (acc_r),
    .divisor  (wsum_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // one tap of the weighted sum
  assign prod = rd_data * $signed({1'b0, weight_r});

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_MAC) && (weight_r == lwma_pkg::WEIGHT_W'(1));
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_r    <= in_sample;
            weight_r <= window_r;
            acc_r    <= '0;
            wsum_r   <= '0;
            state_r  <= hist_stat.win_ok ? S_MAC : S_OUT;
          end
        end
        S_MAC: begin
          acc_r    <= acc_r + lwma_pkg::ACC_W'(prod);
          wsum_r   <= wsum_r + lwma_pkg::WSUM_W'(weight_r);
          weight_r <= weight_r - 1'b1;
          if (weight_r == lwma_pkg::WEIGHT_W'(1)) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_filtered_r <= res_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MAC) || (state_r == S_OUT))
    else $error("request accepted but sequencer stayed idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_mac_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (weight_r != '0))
    else $error("weighted sum walked past the oldest tap");

  a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && !div_done) |=> (state_r == S_DIV))
    else $error("left divide state before quotient was ready");

endmodule

`default_nettype wire
